### hdl/rc4_keystream_generator_core_macros.svh
// assertion helpers, expect clk and rst_n in scope
`ifndef RC4_KEYSTREAM_GENERATOR_CORE_MACROS_SVH
`define RC4_KEYSTREAM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define RC4KG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4kg assertion failed");

// next-cycle implication
`define RC4KG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4kg assertion failed");

`endif

### hdl/rc4kg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4kg_pkg;

    localparam int KEY_WORDS   = 4;
    localparam int KEY_IDX_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 7;
    localparam logic [COUNT_W-1:0] MAX_RUN = 7'd64;
    localparam logic [7:0] LAST_ENTRY = 8'd255;

    localparam logic CMD_RESTART  = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] keystream_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } mem_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_SWAP,
        ST_GEN_OUT
    } state_t;

endpackage

`default_nettype wire

### hdl/rc4_keystream_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// generate: each keystream byte runs these steps on the permutation ram, one read and one write port
//   (read S[i], read S[j], swap write plus read S[t], second swap write); the
//   byte is pushed on the second swap write, which waits while the output register is full
// restart: identity fill of all 256 entries, then the key schedule over every entry
// reset: key words clear to zero, indices to zero; a fill of all 256 entries writes the
//   identity permutation, in_ready stays low meanwhile, config writes still taken

module rc4_keystream_generator_core #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire rc4kg_pkg::in_item_t                  in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output rc4kg_pkg::out_item_t                      out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [rc4kg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rc4kg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [rc4kg_pkg::KEY_WORDS-1:0][7:0][7:0] key_reg;
    logic [rc4kg_pkg::KEY_IDX_W-1:0] key_idx;
    logic [7:0] key_byte;
    logic out_valid_reg, out_valid_next;
    rc4kg_pkg::out_item_t out_data_reg, out_data_next;
    logic out_free;
    logic push;
    rc4kg_pkg::out_item_t push_data;
    rc4kg_pkg::mem_req_t mem_req;
    logic [7:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rc4kg_pkg::REG_KEY_WORD_0: key_reg[0] <= cfg_wdata;
                rc4kg_pkg::REG_KEY_WORD_1: key_reg[1] <= cfg_wdata;
                rc4kg_pkg::REG_KEY_WORD_2: key_reg[2] <= cfg_wdata;
                rc4kg_pkg::REG_KEY_WORD_3: key_reg[3] <= cfg_wdata;
                default: key_reg <= key_reg;
            endcase
        end
    end

    assign key_byte = key_reg[key_idx[4:3]][key_idx[2:0]];

    // output stage
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rc4kg_seq #(
        .KEY_BYTES (KEY_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .key_byte  (key_byte),
        .key_idx   (key_idx),
        .out_free  (out_free),
        .push      (push),
        .push_data (push_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rc4kg_perm_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

### hdl/rc4kg_perm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4kg_perm_ram (
    input  wire logic              clk,
    input  wire rc4kg_pkg::mem_req_t req,
    output logic [7:0]             rdata
);

    logic [7:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

### hdl/rc4kg_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "rc4_keystream_generator_core_macros.svh"

module rc4kg_seq #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire rc4kg_pkg::in_item_t                 in_data,
    input  wire logic [7:0]                          key_byte,
    output logic [rc4kg_pkg::KEY_IDX_W-1:0]          key_idx,
    input  wire logic                                out_free,
    output logic                                     push,
    output rc4kg_pkg::out_item_t                     push_data,
    output rc4kg_pkg::mem_req_t                      mem_req,
    input  wire logic [7:0]                          mem_rdata
);

    localparam logic [rc4kg_pkg::KEY_IDX_W-1:0] KIDX_LAST =
        rc4kg_pkg::KEY_IDX_W'(KEY_BYTES - 1);

    rc4kg_pkg::state_t state_reg, state_next;

    logic [7:0] n_reg, n_next;
    logic [rc4kg_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] t_reg, t_next;
    logic [rc4kg_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic sched_reg, sched_next;

    // shared 8-bit adder
    logic [7:0] add_x, add_y, add_z, add_sum;

    assign add_sum = add_x + add_y + add_z;
    assign key_idx = kidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4kg_pkg::ST_CLEAR;
            n_reg     <= '0;
            kidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            sched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            kidx_reg  <= kidx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            sched_reg <= sched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        t_reg <= t_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        sched_next = sched_reg;
        add_x      = '0;
        add_y      = '0;
        add_z      = '0;
        in_ready   = 1'b0;
        push       = 1'b0;
        push_data.last = (cnt_reg == rc4kg_pkg::COUNT_W'(1));
        // later entries win: j over i, i over memory
        if (t_reg == j_reg)
        begin
            push_data.keystream_byte = a_reg;
        end
        else if (t_reg == i_reg)
        begin
            push_data.keystream_byte = b_reg;
        end
        else
        begin
            push_data.keystream_byte = mem_rdata;
        end
        mem_req.we    = 1'b0;
        mem_req.waddr = n_reg;
        mem_req.wdata = n_reg;
        mem_req.raddr = n_reg;

        unique case (state_reg)
            rc4kg_pkg::ST_CLEAR:
            begin
                mem_req.we = 1'b1;
                n_next     = n_reg + 8'd1;
                kidx_next  = '0;
                j_next     = '0;
                if (n_reg == rc4kg_pkg::LAST_ENTRY)
                begin
                    state_next = sched_reg ? rc4kg_pkg::ST_KS_RD_N : rc4kg_pkg::ST_IDLE;
                end
            end
            rc4kg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.cmd == rc4kg_pkg::CMD_RESTART)
                    begin
                        sched_next = 1'b1;
                        n_next     = '0;
                        state_next = rc4kg_pkg::ST_CLEAR;
                    end
                    else if (in_data.byte_count != '0)
                    begin
                        cnt_next = (in_data.byte_count > rc4kg_pkg::MAX_RUN) ?
                                   rc4kg_pkg::MAX_RUN : in_data.byte_count;
                        state_next = rc4kg_pkg::ST_GEN_RD_I;
                    end
                end
            end
            rc4kg_pkg::ST_KS_RD_N:
            begin
                state_next = rc4kg_pkg::ST_KS_RD_J;
            end
            rc4kg_pkg::ST_KS_RD_J:
            begin
                add_x         = j_reg;
                add_y         = mem_rdata;
                add_z         = key_byte;
                a_next        = mem_rdata;
                j_next        = add_sum;
                mem_req.raddr = add_sum;
                state_next    = rc4kg_pkg::ST_KS_WR_N;
            end
            rc4kg_pkg::ST_KS_WR_N:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
                state_next    = rc4kg_pkg::ST_KS_WR_J;
            end
            rc4kg_pkg::ST_KS_WR_J:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = a_reg;
                n_next        = n_reg + 8'd1;
                kidx_next     = (kidx_reg == KIDX_LAST) ? '0 : kidx_reg + 1'b1;
                if (n_reg == rc4kg_pkg::LAST_ENTRY)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    sched_next = 1'b0;
                    state_next = rc4kg_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4kg_pkg::ST_KS_RD_N;
                end
            end
            rc4kg_pkg::ST_GEN_RD_I:
            begin
                add_x         = i_reg;
                add_y         = 8'd1;
                i_next        = add_sum;
                mem_req.raddr = add_sum;
                state_next    = rc4kg_pkg::ST_GEN_RD_J;
            end
            rc4kg_pkg::ST_GEN_RD_J:
            begin
                add_x         = j_reg;
                add_y         = mem_rdata;
                a_next        = mem_rdata;
                j_next        = add_sum;
                mem_req.raddr = add_sum;
                state_next    = rc4kg_pkg::ST_GEN_SWAP;
            end
            rc4kg_pkg::ST_GEN_SWAP:
            begin
                add_x         = a_reg;
                add_y         = mem_rdata;
                b_next        = mem_rdata;
                t_next        = add_sum;
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = add_sum;
                state_next    = rc4kg_pkg::ST_GEN_OUT;
            end
            rc4kg_pkg::ST_GEN_OUT:
            begin
                // write repeats harmlessly while the output stage is full
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = a_reg;
                mem_req.raddr = t_reg;
                if (out_free)
                begin
                    push     = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    state_next = (cnt_reg == rc4kg_pkg::COUNT_W'(1)) ?
                                 rc4kg_pkg::ST_IDLE : rc4kg_pkg::ST_GEN_RD_I;
                end
            end
            default:
            begin
                state_next = rc4kg_pkg::ST_IDLE;
            end
        endcase
    end

    `RC4KG_ASSERT_IMPL(a_push_room, push, out_free && state_reg == rc4kg_pkg::ST_GEN_OUT)
    `RC4KG_ASSERT_IMPL(a_gen_count, state_reg == rc4kg_pkg::ST_GEN_RD_I || state_reg == rc4kg_pkg::ST_GEN_OUT, cnt_reg != '0 && cnt_reg <= rc4kg_pkg::MAX_RUN)
    `RC4KG_ASSERT_NEXT(a_restart_clears, in_valid && in_ready && in_data.cmd == rc4kg_pkg::CMD_RESTART, state_reg == rc4kg_pkg::ST_CLEAR && sched_reg)
    `RC4KG_ASSERT_NEXT(a_last_idles, push && push_data.last, state_reg == rc4kg_pkg::ST_IDLE)
    `RC4KG_ASSERT_IMPL(a_sched_idx, state_reg == rc4kg_pkg::ST_KS_RD_N, kidx_reg <= KIDX_LAST)

endmodule

`default_nettype wire
